// File: src/iat_pkg.sv
// ----------------------------------------------------------------------------
// iat_pkg
// Shared constants and types of the interleaved address translator.
// ----------------------------------------------------------------------------
package iat_pkg;

  localparam int ADDR_BITS = 64;
  localparam logic [63:0] AddrMask = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - ADDR_BITS);

  localparam int DivStages = 8;
  localparam int DivBits   = 64 / DivStages;

  localparam logic [1:0] RegRegionStart = 2'd0;
  localparam logic [1:0] RegChunkSize   = 2'd1;
  localparam logic [1:0] RegChunkStride = 2'd2;
  localparam logic [1:0] RegLocalOffset = 2'd3;

  localparam logic ActToLocal  = 1'b0;
  localparam logic ActToGlobal = 1'b1;

  typedef struct packed {
    logic        dir;
    logic [63:0] base;
    logic [31:0] rem;
    logic [63:0] dq;
  } div_t;

endpackage

// File: src/iat_if.sv
// ----------------------------------------------------------------------------
// iat_in_if / iat_out_if
// Request and response channels of the translator.
// ----------------------------------------------------------------------------
interface iat_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [63:0] address;
  modport source (output valid, action, address, input ready);
  modport sink (input valid, action, address, output ready);
endinterface

interface iat_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] translated;
  logic        bad_config;
  modport source (output valid, translated, bad_config, input ready);
  modport sink (input valid, translated, bad_config, output ready);
endinterface

// File: src/iat_div_stage.sv
// ----------------------------------------------------------------------------
// iat_div_stage
// One pipeline stage of the restoring divider, DivBits quotient bits.
// ----------------------------------------------------------------------------
module iat_div_stage import iat_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  div_t        data_i,
  input  logic [31:0] divisor_i,
  output logic        valid_o,
  output div_t        data_o
);

  logic valid_q;
  div_t data_q, data_d;

  always_comb begin
    logic [32:0] r;
    data_d = data_i;
    for (int i = 0; i < DivBits; i++) begin
      r = {data_d.rem, data_d.dq[63]};
      data_d.dq = {data_d.dq[62:0], 1'b0};
      if (r >= {1'b0, divisor_i}) begin
        r = r - {1'b0, divisor_i};
        data_d.dq[0] = 1'b1;
      end
      data_d.rem = r[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: src/interleaved_address_translator_top.sv
// ----------------------------------------------------------------------------
// interleaved_address_translator_top
// Global/local address translation for one target of an interleaved region.
// ----------------------------------------------------------------------------
// channel   dir  word
// in_i      in   action, address
// out_o     out  translated, bad_config
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i
//
// One word per cycle while the output is ready; stages: offset, 8 divider
// stages, multiply, sum, final add. The 64/32 divider pipeline sets the depth.
// Reset clears all valid bits and the config registers. Stalls back up stage by
// stage; empty stages are filled while the output waits.
// ----------------------------------------------------------------------------
module interleaved_address_translator_top import iat_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  iat_in_if.sink      in_i,
  iat_out_if.source   out_o
);

  logic [63:0] start_q, offset_q;
  logic [31:0] size_q, stride_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= '0;
      size_q   <= '0;
      stride_q <= '0;
      offset_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegRegionStart: start_q  <= cfg_data_i;
        RegChunkSize:   size_q   <= cfg_data_i[31:0];
        RegChunkStride: stride_q <= cfg_data_i[31:0];
        RegLocalOffset: offset_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic s0_v_q, m_v_q, a_v_q, o_v_q;
  logic adv_0, adv_m, adv_a, adv_o;
  logic [DivStages:1] dv, dadv;
  div_t dd [DivStages+1];

  logic        s0_dir_q;
  logic [63:0] s0_base_q;

  assign adv_o = !o_v_q || out_o.ready;
  assign adv_a = !a_v_q || adv_o;
  assign adv_m = !m_v_q || adv_a;
  assign adv_0 = !s0_v_q || dadv[1];
  assign in_i.ready = adv_0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else if (adv_0) begin
      s0_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_0) begin
      s0_dir_q  <= in_i.action;
      s0_base_q <= ((in_i.address & AddrMask) -
                    ((in_i.action == ActToGlobal) ? offset_q : start_q)) & AddrMask;
    end
  end

  assign dd[0] = '{dir: s0_dir_q, base: s0_base_q, rem: '0, dq: s0_base_q};

  for (genvar k = 1; k <= DivStages; k++) begin : g_div
    if (k == DivStages) begin : g_last
      assign dadv[k] = !dv[k] || adv_m;
    end else begin : g_mid
      assign dadv[k] = !dv[k] || dadv[k+1];
    end
    iat_div_stage u_stage (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (dadv[k]),
      .valid_i   ((k == 1) ? s0_v_q : dv[(k == 1) ? 1 : k-1]),
      .data_i    (dd[k-1]),
      .divisor_i ((dd[k-1].dir == ActToGlobal) ? size_q : stride_q),
      .valid_o   (dv[k]),
      .data_o    (dd[k])
    );
  end

  logic        m_dir_q;
  logic [63:0] m_base_q, m_plo_q;
  logic [31:0] m_phi_q, m_rem_q;
  logic [31:0] mul;
  div_t        dl;

  assign dl  = dd[DivStages];
  assign mul = (dl.dir == ActToGlobal) ? stride_q : size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
      a_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else begin
      if (adv_m) m_v_q <= dv[DivStages];
      if (adv_a) a_v_q <= m_v_q;
      if (adv_o) o_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_m) begin
      m_dir_q  <= dl.dir;
      m_base_q <= dl.base;
      m_rem_q  <= dl.rem;
      m_plo_q  <= dl.dq[31:0] * mul;
      m_phi_q  <= 32'(dl.dq[63:32] * mul);
    end
  end

  logic        a_dir_q, a_bad_q, lin;
  logic [63:0] a_sum_q, sum_d;

  assign lin   = (size_q == '0);
  assign sum_d = m_plo_q + {m_phi_q, 32'b0} + {32'b0, m_rem_q};

  always_ff @(posedge clk_i) begin
    if (adv_a) begin
      a_dir_q <= m_dir_q;
      a_bad_q <= (m_dir_q == ActToLocal) && !lin && (stride_q == '0);
      a_sum_q <= lin ? m_base_q : sum_d;
    end
  end

  logic        o_bad_q;
  logic [63:0] o_res_q;

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      o_bad_q <= a_bad_q;
      o_res_q <= a_bad_q ? '0 :
                 ((a_sum_q + ((a_dir_q == ActToGlobal) ? start_q : offset_q)) & AddrMask);
    end
  end

  assign out_o.valid      = o_v_q;
  assign out_o.translated = o_res_q;
  assign out_o.bad_config = o_bad_q;

`ifndef ASSERT_OFF
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_v_q && o_bad_q |-> o_res_q == '0) else $error("bad word not zero");
  a_lin_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_v_q && lin |-> !a_bad_q) else $error("linear mode flagged bad");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_v_q && !adv_o |=> a_v_q) else $error("stalled word lost");
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s0_v_q |-> in_i.ready) else $error("empty front not ready");
`endif

endmodule
